// ----- design/pkl_pkg.sv -----
package pkl_pkg;

  // List geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);

  // Field widths
  localparam int unsigned CmdW = 3;
  localparam int unsigned PosW = 7;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned StW  = 3;
  localparam int unsigned EntW = KeyW + ValW;
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  // Command codes
  localparam logic [CmdW-1:0] CmdSearch    = 3'd0;
  localparam logic [CmdW-1:0] CmdUpdate    = 3'd1;
  localparam logic [CmdW-1:0] CmdInsert    = 3'd2;
  localparam logic [CmdW-1:0] CmdDelFirst  = 3'd3;
  localparam logic [CmdW-1:0] CmdDelLast   = 3'd4;
  localparam logic [CmdW-1:0] CmdDelPos    = 3'd5;
  localparam logic [CmdW-1:0] CmdSearchUpd = 3'd6;

  // Status codes
  localparam logic [StW-1:0] StOk     = 3'd0;
  localparam logic [StW-1:0] StAbsent = 3'd1;
  localparam logic [StW-1:0] StEmpty  = 3'd2;
  localparam logic [StW-1:0] StBelow  = 3'd3;
  localparam logic [StW-1:0] StFull   = 3'd4;

  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic [PosW-1:0]        position;
    logic signed [KeyW-1:0] entry_key;
    logic signed [ValW-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [StW-1:0]         status;
    logic signed [ValW-1:0] hit_value;
    logic [PosW-1:0]        hit_position;
    logic [PosW-1:0]        list_length;
  } rsp_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [EntW-1:0] wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

// ----- design/pkl_ram.sv -----
module pkl_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pkl_seq.sv -----
module pkl_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  pkl_pkg::req_t            req_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output pkl_pkg::rsp_t            rsp_o,
  output pkl_pkg::mem_req_t        mem_o,
  input  logic [pkl_pkg::EntW-1:0] mem_rdata_i
);

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SSearch = 6'b000010,
    SUpdate = 6'b000100,
    SShUp   = 6'b001000,
    SShDn   = 6'b010000,
    SFin    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [pkl_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [pkl_pkg::CntW-1:0] cur_q, cur_d;
  logic [pkl_pkg::CntW-1:0] lo_q, lo_d;
  logic [pkl_pkg::IdxW-1:0] pidx_q, pidx_d;
  logic                     pend_q, pend_d;
  logic [pkl_pkg::CmdW-1:0] cmd_q, cmd_d;
  logic [pkl_pkg::KeyW-1:0] key_q, key_d;
  logic [pkl_pkg::ValW-1:0] val_q, val_d;
  logic [pkl_pkg::StW-1:0]  st_q, st_d;
  logic [pkl_pkg::ValW-1:0] hval_q, hval_d;
  logic [pkl_pkg::CntW-1:0] hpos_q, hpos_d;

  logic [pkl_pkg::CmpW-1:0] pos_ext, cnt_ext;
  logic [pkl_pkg::CntW-1:0] pos_m1;
  logic                     pos_zero;
  logic [pkl_pkg::KeyW-1:0] rd_key;
  logic [pkl_pkg::ValW-1:0] rd_val;

  assign pos_ext  = pkl_pkg::CmpW'(req_i.position);
  assign cnt_ext  = pkl_pkg::CmpW'(cnt_q);
  assign pos_zero = (req_i.position == '0);
  assign pos_m1   = pkl_pkg::CntW'(pos_ext - pkl_pkg::CmpW'(1));
  assign rd_key   = mem_rdata_i[pkl_pkg::EntW-1 -: pkl_pkg::KeyW];
  assign rd_val   = mem_rdata_i[pkl_pkg::ValW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    lo_d    = lo_q;
    pidx_d  = pidx_q;
    pend_d  = pend_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    val_d   = val_q;
    st_d    = st_q;
    hval_d  = hval_q;
    hpos_d  = hpos_q;
    mem_o   = '0;

    unique case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          cmd_d   = req_i.cmd;
          key_d   = req_i.entry_key;
          val_d   = req_i.entry_value;
          st_d    = pkl_pkg::StAbsent;
          hval_d  = '0;
          hpos_d  = '0;
          pend_d  = 1'b0;
          state_d = SFin;
          unique case (req_i.cmd) inside
            pkl_pkg::CmdSearch, pkl_pkg::CmdSearchUpd: begin
              cur_d   = '0;
              state_d = SSearch;
            end
            pkl_pkg::CmdUpdate: begin
              if (pos_zero) begin
                st_d = pkl_pkg::StBelow;
              end else if (pos_ext <= cnt_ext) begin
                lo_d    = pos_m1;
                cur_d   = pos_m1;
                state_d = SUpdate;
              end
            end
            pkl_pkg::CmdInsert: begin
              if (pos_zero) begin
                st_d = pkl_pkg::StBelow;
              end else if (cnt_q == pkl_pkg::CntW'(pkl_pkg::CAPACITY)) begin
                st_d = pkl_pkg::StFull;
              end else if (pos_ext <= cnt_ext + pkl_pkg::CmpW'(1)) begin
                lo_d    = pos_m1;
                cur_d   = cnt_q;
                state_d = SShUp;
              end
            end
            pkl_pkg::CmdDelFirst: begin
              if (cnt_q == '0) begin
                st_d = pkl_pkg::StEmpty;
              end else begin
                lo_d    = '0;
                cur_d   = '0;
                state_d = SShDn;
              end
            end
            pkl_pkg::CmdDelLast: begin
              if (cnt_q == '0) begin
                st_d = pkl_pkg::StEmpty;
              end else begin
                lo_d    = cnt_q - pkl_pkg::CntW'(1);
                cur_d   = cnt_q - pkl_pkg::CntW'(1);
                state_d = SShDn;
              end
            end
            pkl_pkg::CmdDelPos: begin
              if (pos_zero) begin
                st_d = pkl_pkg::StBelow;
              end else if (pos_ext <= cnt_ext) begin
                lo_d    = pos_m1;
                cur_d   = pos_m1;
                state_d = SShDn;
              end
            end
            default: ;
          endcase
        end
      end

      SSearch: begin
        if (pend_q && (rd_key == key_q)) begin
          st_d    = pkl_pkg::StOk;
          hval_d  = rd_val;
          hpos_d  = pkl_pkg::CntW'(pidx_q) + pkl_pkg::CntW'(1);
          pend_d  = 1'b0;
          state_d = SFin;
          if (cmd_q == pkl_pkg::CmdSearchUpd) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = pidx_q;
            mem_o.wdata = {key_q, val_q};
          end
        end else if (cur_q < cnt_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = pkl_pkg::IdxW'(cur_q);
          pidx_d      = pkl_pkg::IdxW'(cur_q);
          pend_d      = 1'b1;
          cur_d       = cur_q + pkl_pkg::CntW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = SFin;
          end
        end
      end

      SUpdate: begin
        if (!pend_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = pkl_pkg::IdxW'(cur_q);
          pidx_d      = pkl_pkg::IdxW'(cur_q);
          pend_d      = 1'b1;
        end else begin
          mem_o.we    = 1'b1;
          mem_o.waddr = pidx_q;
          mem_o.wdata = {rd_key, val_q};
          st_d        = pkl_pkg::StOk;
          hval_d      = rd_val;
          hpos_d      = lo_q + pkl_pkg::CntW'(1);
          pend_d      = 1'b0;
          state_d     = SFin;
        end
      end

      SShUp: begin
        if (pend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = pkl_pkg::IdxW'(pkl_pkg::CntW'(pidx_q) + pkl_pkg::CntW'(1));
          mem_o.wdata = mem_rdata_i;
        end
        if (cur_q > lo_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = pkl_pkg::IdxW'(cur_q - pkl_pkg::CntW'(1));
          pidx_d      = pkl_pkg::IdxW'(cur_q - pkl_pkg::CntW'(1));
          pend_d      = 1'b1;
          cur_d       = cur_q - pkl_pkg::CntW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = pkl_pkg::IdxW'(lo_q);
            mem_o.wdata = {key_q, val_q};
            cnt_d       = cnt_q + pkl_pkg::CntW'(1);
            st_d        = pkl_pkg::StOk;
            hpos_d      = lo_q + pkl_pkg::CntW'(1);
            state_d     = SFin;
          end
        end
      end

      SShDn: begin
        if (pend_q) begin
          if (pidx_q == pkl_pkg::IdxW'(lo_q)) begin
            hval_d = rd_val;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.waddr = pidx_q - pkl_pkg::IdxW'(1);
            mem_o.wdata = mem_rdata_i;
          end
        end
        if (cur_q < cnt_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = pkl_pkg::IdxW'(cur_q);
          pidx_d      = pkl_pkg::IdxW'(cur_q);
          pend_d      = 1'b1;
          cur_d       = cur_q + pkl_pkg::CntW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d   = cnt_q - pkl_pkg::CntW'(1);
            st_d    = pkl_pkg::StOk;
            hpos_d  = lo_q + pkl_pkg::CntW'(1);
            state_d = SFin;
          end
        end
      end

      SFin: begin
        if (rsp_ready_i) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    lo_q   <= lo_d;
    pidx_q <= pidx_d;
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    val_q  <= val_d;
    st_q   <= st_d;
    hval_q <= hval_d;
    hpos_q <= hpos_d;
  end

  assign req_ready_o        = (state_q == SIdle);
  assign rsp_valid_o        = (state_q == SFin);
  assign rsp_o.status       = st_q;
  assign rsp_o.hit_value    = hval_q;
  assign rsp_o.hit_position = pkl_pkg::PosW'(hpos_q);
  assign rsp_o.list_length  = pkl_pkg::PosW'(cnt_q);

endmodule

// ----- design/positional_keyed_list.sv -----
// Positional keyed list: an ordered list of key/value entries, position 1 at
// the front, held in one single-port-read, single-port-write RAM.
// Request channel (in_valid_i/in_ready_o/in_data_i): one beat carries a
// command, a position, a key and a value. Response channel (out_valid_o/
// out_ready_i/out_data_o): exactly one beat per request, in request order,
// with status, hit value, hit position and the list length afterwards.
// The RAM gives one entry per cycle. A key search walks from the front up
// to the first match, an insert moves the entries at and behind the
// position up by one, a delete moves the entries behind the position
// down by one, and a positional update is a read and a write back.
// Rejected requests are answered without touching the RAM.
// One request is worked at a time; the next request is taken as soon as the
// previous result has moved into the output register.
// Reset clears the list length and the handshake state; the RAM is not
// cleared, since only entries below the length are ever read.
// When the receiver stalls, the output register holds its beat, and the
// sequencer holds a finished result until that register frees up.
module positional_keyed_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pkl_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pkl_pkg::rsp_t out_data_o
);

  pkl_pkg::mem_req_t        mem_req;
  logic [pkl_pkg::EntW-1:0] mem_rdata;

  logic          seq_rsp_valid;
  logic          seq_rsp_ready;
  pkl_pkg::rsp_t seq_rsp;

  logic          out_valid_q, out_valid_d;
  pkl_pkg::rsp_t out_data_q;

  // Entry store: key in the upper half, value in the lower half
  pkl_ram #(
    .Width(pkl_pkg::EntW),
    .Depth(pkl_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(mem_rdata)
  );

  // Command sequencer: checks, walks and shifts the list through the RAM
  pkl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o),
    .req_i      (in_data_i),
    .rsp_valid_o(seq_rsp_valid),
    .rsp_ready_i(seq_rsp_ready),
    .rsp_o      (seq_rsp),
    .mem_o      (mem_req),
    .mem_rdata_i(mem_rdata)
  );

  // Output register: load when empty or when the held beat leaves now
  assign seq_rsp_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_rsp_valid && seq_rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_rsp_valid && seq_rsp_ready) begin
      out_data_q <= seq_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
